// ----- design/first_fit_extent_allocator_unit_macros.svh -----
// Assertion helpers for the extent allocator checker.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef FIRST_FIT_EXTENT_ALLOCATOR_UNIT_MACROS_SVH
`define FIRST_FIT_EXTENT_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication.
`define FFEA_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ffea checker: property violated");

// Next-cycle implication.
`define FFEA_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ffea checker: property violated");

`endif

// ----- design/ffea_pkg.sv -----
package ffea_pkg;

  // Geometry
  localparam int unsigned MaxExtentsDef = 16;
  localparam int unsigned PageShift     = 12;
  localparam int unsigned AddrW         = 32;
  localparam int unsigned PageW         = AddrW - PageShift;
  localparam int unsigned PagesW        = PageW + 1;
  localparam int unsigned StatusW       = 3;
  localparam int unsigned TotalW        = 5;
  localparam int unsigned CfgIdxW       = 1;

  // Configuration registers
  localparam logic [CfgIdxW-1:0] RegPoolStart = 1'b0;
  localparam logic [CfgIdxW-1:0] RegPoolEnd   = 1'b1;
  localparam logic [AddrW-1:0]   PoolStartRst = 32'h0030_0000;
  localparam logic [AddrW-1:0]   PoolEndRst   = 32'h1FF0_0000;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_INIT  = 2'd2
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 3'd0,
    ST_MISALIGN = 3'd1,
    ST_NOSPACE  = 3'd2,
    ST_FULL     = 3'd3,
    ST_BAD      = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [AddrW-1:0] request_bytes;
    logic [AddrW-1:0] free_start;
    logic [AddrW-1:0] free_end;
  } in_item_t;

  typedef struct packed {
    logic [AddrW-1:0]   phys_addr;
    logic [StatusW-1:0] status;
    logic [TotalW-1:0]  extent_total;
  } out_item_t;

  // One free extent: first page and length in pages
  typedef struct packed {
    logic [PageW-1:0]  base;
    logic [PagesW-1:0] pages;
  } entry_t;

  typedef enum logic [1:0] {
    RD_IDX     = 2'd0,
    RD_SH_NEXT = 2'd1,
    RD_SH_PREV = 2'd2
  } rd_sel_e;

  typedef enum logic [2:0] {
    WR_NONE       = 3'd0,
    WR_PREV_MERGE = 3'd1,
    WR_NEXT_MERGE = 3'd2,
    WR_NEW        = 3'd3,
    WR_SHRINK     = 3'd4,
    WR_SHIFT      = 3'd5
  } wr_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic    load;
    logic    idx_clr;
    logic    idx_inc;
    logic    cap_prev;
    logic    cap_cur;
    logic    sh_load_down;
    logic    sh_load_up;
    logic    sh_inc;
    logic    sh_dec;
    logic    rd_en;
    rd_sel_e rd_sel;
    wr_sel_e wr_sel;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    finish;
    status_e fin_status;
  } ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic    is_alloc;
    logic    chk_fail;
    status_e chk_code;
    logic    scan_end;
    logic    hit;
    logic    exact;
    logic    join_prev;
    logic    join_next;
    logic    full;
    logic    sh_down_more;
    logic    sh_up_more;
  } stat_t;

endpackage

// ----- design/ffea_ctrl.sv -----
module ffea_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  ffea_pkg::stat_t stat_i,
  output ffea_pkg::ctl_t  ctl_o
);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_CHECK   = 10'b00_0000_0010,
    S_SCAN_RD = 10'b00_0000_0100,
    S_SCAN_EV = 10'b00_0000_1000,
    S_ALLOC   = 10'b00_0001_0000,
    S_DECIDE  = 10'b00_0010_0000,
    S_SHD_RD  = 10'b00_0100_0000,
    S_SHD_WR  = 10'b00_1000_0000,
    S_SHU_RD  = 10'b01_0000_0000,
    S_SHU_WR  = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  // Sequence one command through check, scan, update and shift
  always_comb begin
    state_d          = state_q;
    ctl_o            = '0;
    ctl_o.rd_sel     = ffea_pkg::RD_IDX;
    ctl_o.wr_sel     = ffea_pkg::WR_NONE;
    ctl_o.fin_status = ffea_pkg::ST_OK;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          ctl_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.chk_fail) begin
          ctl_o.finish     = 1'b1;
          ctl_o.fin_status = stat_i.chk_code;
          state_d          = S_IDLE;
        end else begin
          ctl_o.idx_clr = 1'b1;
          state_d       = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (stat_i.scan_end) begin
          if (stat_i.is_alloc) begin
            ctl_o.finish     = 1'b1;
            ctl_o.fin_status = ffea_pkg::ST_NOSPACE;
            state_d          = S_IDLE;
          end else begin
            state_d = S_DECIDE;
          end
        end else begin
          ctl_o.rd_en = 1'b1;
          state_d     = S_SCAN_EV;
        end
      end
      S_SCAN_EV: begin
        if (stat_i.hit) begin
          ctl_o.cap_cur = 1'b1;
          state_d       = stat_i.is_alloc ? S_ALLOC : S_DECIDE;
        end else begin
          ctl_o.cap_prev = 1'b1;
          ctl_o.idx_inc  = 1'b1;
          state_d        = S_SCAN_RD;
        end
      end
      S_ALLOC: begin
        if (stat_i.exact) begin
          ctl_o.sh_load_down = 1'b1;
          state_d            = S_SHD_RD;
        end else begin
          ctl_o.wr_sel = ffea_pkg::WR_SHRINK;
          ctl_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_DECIDE: begin
        if (stat_i.join_prev) begin
          ctl_o.wr_sel = ffea_pkg::WR_PREV_MERGE;
          if (stat_i.join_next) begin
            ctl_o.sh_load_down = 1'b1;
            state_d            = S_SHD_RD;
          end else begin
            ctl_o.finish = 1'b1;
            state_d      = S_IDLE;
          end
        end else if (stat_i.join_next) begin
          ctl_o.wr_sel = ffea_pkg::WR_NEXT_MERGE;
          ctl_o.finish = 1'b1;
          state_d      = S_IDLE;
        end else if (stat_i.full) begin
          ctl_o.finish     = 1'b1;
          ctl_o.fin_status = ffea_pkg::ST_FULL;
          state_d          = S_IDLE;
        end else begin
          ctl_o.sh_load_up = 1'b1;
          state_d          = S_SHU_RD;
        end
      end
      // Close the gap: move entries above the removed one down by one
      S_SHD_RD: begin
        if (stat_i.sh_down_more) begin
          ctl_o.rd_en  = 1'b1;
          ctl_o.rd_sel = ffea_pkg::RD_SH_NEXT;
          state_d      = S_SHD_WR;
        end else begin
          ctl_o.cnt_dec = 1'b1;
          ctl_o.finish  = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_SHD_WR: begin
        ctl_o.wr_sel = ffea_pkg::WR_SHIFT;
        ctl_o.sh_inc = 1'b1;
        state_d      = S_SHD_RD;
      end
      // Open a gap: move entries from the top down to the insert slot up by one
      S_SHU_RD: begin
        if (stat_i.sh_up_more) begin
          ctl_o.rd_en  = 1'b1;
          ctl_o.rd_sel = ffea_pkg::RD_SH_PREV;
          state_d      = S_SHU_WR;
        end else begin
          ctl_o.wr_sel  = ffea_pkg::WR_NEW;
          ctl_o.cnt_inc = 1'b1;
          ctl_o.finish  = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_SHU_WR: begin
        ctl_o.wr_sel = ffea_pkg::WR_SHIFT;
        ctl_o.sh_dec = 1'b1;
        state_d      = S_SHU_RD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ----- design/ffea_dpath.sv -----
module ffea_dpath #(
  parameter int unsigned MAX_EXTENTS = ffea_pkg::MaxExtentsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ffea_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ffea_pkg::AddrW-1:0]    cfg_wdata_i,
  input  ffea_pkg::in_item_t            item_i,
  input  ffea_pkg::ctl_t                ctl_i,
  output ffea_pkg::stat_t               stat_o,
  output logic                          done_o,
  output ffea_pkg::out_item_t           result_o
);

  localparam int unsigned CntW   = $clog2(MAX_EXTENTS + 1);
  localparam int unsigned IdxW   = $clog2(MAX_EXTENTS);
  localparam int unsigned PS     = ffea_pkg::PageShift;
  localparam int unsigned AW     = ffea_pkg::AddrW;
  localparam int unsigned PageW  = ffea_pkg::PageW;
  localparam int unsigned PagesW = ffea_pkg::PagesW;

  // Pool registers
  logic [AW-1:0] pool_start_q, pool_end_q;

  // Latched command
  logic [1:0]    cmd_q;
  logic [AW-1:0] req_q, fs_q, fe_q;

  // Table bookkeeping
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] idx_q, sh_q;
  logic [CntW-1:0] sh_next, sh_prev, idx_prev;
  ffea_pkg::entry_t prev_q, cur_q, rd_data_q;
  ffea_pkg::entry_t mem [MAX_EXTENTS];

  // Result register
  logic                done_q;
  ffea_pkg::out_item_t result_q;

  // Derived page quantities
  logic [PageW-1:0]  need, sp, np;
  logic              is_alloc, is_free;
  logic [PageW+1:0]  prev_end;
  logic [PageW:0]    new_end;

  // Memory access
  logic             wr_en;
  logic [IdxW-1:0]  wr_addr, rd_addr;
  ffea_pkg::entry_t wr_data;
  logic [PagesW-1:0] merge_add;
  logic [31:0]       cnt_wide;

  assign need     = req_q[AW-1:PS];
  assign sp       = fs_q[AW-1:PS];
  assign np       = fe_q[AW-1:PS] - fs_q[AW-1:PS];
  assign is_alloc = (cmd_q == ffea_pkg::CMD_ALLOC);
  assign is_free  = (cmd_q == ffea_pkg::CMD_FREE) || (cmd_q == ffea_pkg::CMD_INIT);
  assign prev_end = {2'b00, prev_q.base} + {1'b0, prev_q.pages};
  assign new_end  = {1'b0, sp} + {1'b0, np};
  assign sh_next  = sh_q + CntW'(1);
  assign sh_prev  = sh_q - CntW'(1);
  assign idx_prev = idx_q - CntW'(1);

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_start_q <= ffea_pkg::PoolStartRst;
      pool_end_q   <= ffea_pkg::PoolEndRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ffea_pkg::RegPoolStart: pool_start_q <= cfg_wdata_i;
        ffea_pkg::RegPoolEnd:   pool_end_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Capture the item; init takes its range from the pool registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q <= item_i.cmd;
      req_q <= item_i.request_bytes;
      if (item_i.cmd == ffea_pkg::CMD_INIT) begin
        fs_q <= pool_start_q;
        fe_q <= pool_end_q;
      end else begin
        fs_q <= item_i.free_start;
        fe_q <= item_i.free_end;
      end
    end
  end

  // Check alignment and range; report scan and merge conditions
  always_comb begin
    stat_o.chk_fail = 1'b1;
    stat_o.chk_code = ffea_pkg::ST_BAD;
    if (is_alloc) begin
      if (req_q[PS-1:0] != '0) begin
        stat_o.chk_code = ffea_pkg::ST_MISALIGN;
      end else if (req_q == '0) begin
        stat_o.chk_code = ffea_pkg::ST_BAD;
      end else begin
        stat_o.chk_fail = 1'b0;
      end
    end else if (is_free) begin
      if ((fs_q[PS-1:0] != '0) || (fe_q[PS-1:0] != '0)) begin
        stat_o.chk_code = ffea_pkg::ST_MISALIGN;
      end else if (fe_q <= fs_q) begin
        stat_o.chk_code = ffea_pkg::ST_BAD;
      end else begin
        stat_o.chk_fail = 1'b0;
      end
    end
    stat_o.is_alloc     = is_alloc;
    stat_o.scan_end     = (idx_q >= cnt_q);
    stat_o.hit          = is_alloc ? (rd_data_q.pages >= {1'b0, need})
                                   : (rd_data_q.base >= sp);
    stat_o.exact        = (cur_q.pages == {1'b0, need});
    stat_o.join_prev    = (idx_q != '0) && (prev_end == {2'b00, sp});
    stat_o.join_next    = (idx_q < cnt_q) && (new_end == {1'b0, cur_q.base});
    stat_o.full         = (cnt_q >= CntW'(MAX_EXTENTS));
    stat_o.sh_down_more = (sh_next < cnt_q);
    stat_o.sh_up_more   = (sh_q > idx_q);
  end

  // Advance scan index, shift pointer and entry count
  always_comb begin
    cnt_d = cnt_q;
    if (ctl_i.load && (item_i.cmd == ffea_pkg::CMD_INIT)) begin
      cnt_d = '0;
    end else if (ctl_i.cnt_inc) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (ctl_i.cnt_dec) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
      sh_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (ctl_i.idx_clr) begin
        idx_q <= '0;
      end else if (ctl_i.idx_inc) begin
        idx_q <= idx_q + CntW'(1);
      end
      if (ctl_i.sh_load_down) begin
        sh_q <= idx_q;
      end else if (ctl_i.sh_load_up) begin
        sh_q <= cnt_q;
      end else if (ctl_i.sh_inc) begin
        sh_q <= sh_next;
      end else if (ctl_i.sh_dec) begin
        sh_q <= sh_prev;
      end
    end
  end

  // Hold the neighbors of the scan position
  always_ff @(posedge clk_i) begin
    if (ctl_i.cap_prev) begin
      prev_q <= rd_data_q;
    end
    if (ctl_i.cap_cur) begin
      cur_q <= rd_data_q;
    end
  end

  // Select the table read address
  always_comb begin
    case (ctl_i.rd_sel)
      ffea_pkg::RD_IDX:     rd_addr = idx_q[IdxW-1:0];
      ffea_pkg::RD_SH_NEXT: rd_addr = sh_next[IdxW-1:0];
      ffea_pkg::RD_SH_PREV: rd_addr = sh_prev[IdxW-1:0];
      default:              rd_addr = idx_q[IdxW-1:0];
    endcase
  end

  // Build the table write
  assign merge_add = stat_o.join_next ? cur_q.pages : '0;

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = idx_q[IdxW-1:0];
    wr_data = rd_data_q;
    case (ctl_i.wr_sel)
      ffea_pkg::WR_PREV_MERGE: begin
        wr_addr       = idx_prev[IdxW-1:0];
        wr_data.base  = prev_q.base;
        wr_data.pages = prev_q.pages + {1'b0, np} + merge_add;
      end
      ffea_pkg::WR_NEXT_MERGE: begin
        wr_data.base  = sp;
        wr_data.pages = cur_q.pages + {1'b0, np};
      end
      ffea_pkg::WR_NEW: begin
        wr_data.base  = sp;
        wr_data.pages = {1'b0, np};
      end
      ffea_pkg::WR_SHRINK: begin
        wr_data.base  = cur_q.base + need;
        wr_data.pages = cur_q.pages - {1'b0, need};
      end
      ffea_pkg::WR_SHIFT: begin
        wr_addr = sh_q[IdxW-1:0];
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Extent table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // Register the result item and its done flag
  assign cnt_wide = 32'(cnt_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.finish) begin
      result_q.status       <= ctl_i.fin_status;
      result_q.extent_total <= cnt_wide[ffea_pkg::TotalW-1:0];
      if (is_alloc && (ctl_i.fin_status == ffea_pkg::ST_OK)) begin
        result_q.phys_addr <= {cur_q.base, {PS{1'b0}}};
      end else begin
        result_q.phys_addr <= '0;
      end
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

// ----- design/first_fit_extent_allocator_unit.sv -----
// First-fit allocator over an address-sorted table of free 4 KiB-page extents.
// Pulse start with a command while busy is low: alloc returns the page-aligned
// base of the low part of the first extent big enough, free inserts a range and
// merges it with exactly touching neighbors, init reloads the table with the
// pool_start..pool_end range. Every command yields one result on result_o,
// marked by done_o for exactly one cycle; there is no back-pressure, so capture
// it in that cycle. busy is already low when done_o rises, and the next start
// may be given then. A command rejected on its checks ends in the check state;
// the extent table has one write port and one registered read port, so every
// entry scanned passes through a read and an evaluate state, and every entry
// moved on insert or removal through a read and a write state.
// The table comes out of reset empty; no clearing pass is needed.
// Configuration writes are taken at any cycle and belong in idle periods.
module first_fit_extent_allocator_unit #(
  parameter int unsigned MAX_EXTENTS = ffea_pkg::MaxExtentsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ffea_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [ffea_pkg::AddrW-1:0]   cfg_wdata_i,
  input  logic                         start,
  output logic                         busy,
  input  ffea_pkg::in_item_t           item_i,
  output logic                         done_o,
  output ffea_pkg::out_item_t          result_o
);

  ffea_pkg::ctl_t  ctl;
  ffea_pkg::stat_t stat;

  ffea_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  ffea_dpath #(
    .MAX_EXTENTS (MAX_EXTENTS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_i),
    .ctl_i       (ctl),
    .stat_o      (stat),
    .done_o      (done_o),
    .result_o    (result_o)
  );

endmodule

// ----- design/ffea_checker.sv -----
`include "first_fit_extent_allocator_unit_macros.svh"

module ffea_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                done_o,
  input ffea_pkg::out_item_t result_o
);

  // An accepted item makes the block busy in the next cycle
  `FFEA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

  // The block goes idle only when it delivers a result
  `FFEA_ASSERT_IMPL(a_idle_with_result, $fell(busy), done_o)

  // Status is one of the defined codes
  `FFEA_ASSERT_IMPL(a_status_legal, done_o, (result_o.status == ffea_pkg::ST_OK) || (result_o.status == ffea_pkg::ST_MISALIGN) || (result_o.status == ffea_pkg::ST_NOSPACE) || (result_o.status == ffea_pkg::ST_FULL) || (result_o.status == ffea_pkg::ST_BAD))

  // A failed command returns no address
  `FFEA_ASSERT_IMPL(a_fail_no_addr, done_o && (result_o.status != ffea_pkg::ST_OK), result_o.phys_addr == '0)

endmodule

bind first_fit_extent_allocator_unit ffea_checker u_ffea_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);
